/* rtl/assert_macros.svh */
// Assertion macros used by the frontier search RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/ffill_pkg.sv */
// Package for the frontier flood fill block: command and cell class codes.
// No dependencies.
package ffill_pkg;
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_START = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [1:0] CLASS_FREE    = 2'd0;
   localparam logic [1:0] CLASS_BLOCKED = 2'd1;
   localparam logic [1:0] CLASS_UNKNOWN = 2'd2;
   localparam logic [1:0] CLASS_OTHER   = 2'd3;
endpackage

/* rtl/frontier_flood_fill.sv */
// Frontier flood fill top level: sequencer, grid store, visited map, queue.
// Depends on ffill_pkg and assert_macros.svh.
//
//  channel | dir | tdata (low bit up)                         | tuser
//  req     | in  | cmd[1:0] x[9:2] y[17:10] class[19:18], 24b | -
//  rsp     | out | x[7:0] y[15:8] popped[16] front[17] done[18], 24b | -
//  csr     | in  | index 1b, data 9b                          | -
//
// A write passes through the write state and back to idle. A step on an empty
// queue answers from the pop state, else it runs pop and pop read, center and
// 8-ring reads on one grid port, per 4-neighbour a check, a visited read and a
// push where needed, a last check and the output state.
// A start clears the visited map one bit a cycle, then pushes the start cell if
// it lies in the grid; the clear pass also runs after reset before req_tready rises.
// A waiting result holds req_tready low until its rsp transfer.
`include "assert_macros.svh"
module frontier_flood_fill #(
   parameter int MAX_GRID_WIDTH  = 256,
   parameter int MAX_GRID_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cmd, cell_x, cell_y, cell_class
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_x, out_y, popped_valid, is_frontier, search_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);
   import ffill_pkg::*;

   // cells are addressed {y, x}; coordinates are 8 bits whatever the store size
   localparam int XW = 8;
   localparam int YW = 8;
   localparam int AW = XW + YW;
   localparam int CELLS = 1 << AW;
   localparam int EW = (MAX_GRID_WIDTH < 256) ? MAX_GRID_WIDTH : 256;
   localparam int EH = (MAX_GRID_HEIGHT < 256) ? MAX_GRID_HEIGHT : 256;
   localparam int QD = 65536;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WRITE, S_POP, S_POPRD, S_CENTER, S_NBR, S_NBRWAIT,
      S_VIS, S_VISWAIT, S_PUSH, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [8:0]  gw_ff, gh_ff;
   logic [8:0]  ew, eh;
   logic [AW-1:0] clr_ff;
   logic [16:0] head_ff, tail_ff;
   logic [7:0]  px_ff, py_ff, sx_ff, sy_ff;
   logic [1:0]  scls_ff;
   logic [3:0]  k_ff;
   logic        front_ff, cfree_ff, unk_ff, startq_ff;
   logic        rv_ff;
   logic [23:0] rd_ff;
   logic        nin_d;

   logic [1:0]  grid_mem [CELLS];
   logic        vis_mem  [CELLS];
   logic [15:0] q_mem    [QD];
   logic [1:0]  grid_q;
   logic        vis_q;
   logic [15:0] q_q;

   // effective grid size
   always_comb begin
      ew = (gw_ff == 9'd0) ? 9'd1 : gw_ff;
      if (ew > 9'(EW)) ew = 9'(EW);
      eh = (gh_ff == 9'd0) ? 9'd1 : gh_ff;
      if (eh > 9'(EH)) eh = 9'(EH);
   end

   // neighbour offset k: 0..7 eight-ring, 8..11 four-neighbours +x -x +y -y
   logic signed [9:0] nx, ny, dx, dy;
   logic              nin;
   logic [AW-1:0]     naddr;
   always_comb begin
      dx = 10'sd0; dy = 10'sd0;
      case (k_ff)
         4'd0: begin dx = -10'sd1; dy = -10'sd1; end
         4'd1: begin dx =  10'sd0; dy = -10'sd1; end
         4'd2: begin dx =  10'sd1; dy = -10'sd1; end
         4'd3: begin dx = -10'sd1; dy =  10'sd0; end
         4'd4: begin dx =  10'sd1; dy =  10'sd0; end
         4'd5: begin dx = -10'sd1; dy =  10'sd1; end
         4'd6: begin dx =  10'sd0; dy =  10'sd1; end
         4'd7: begin dx =  10'sd1; dy =  10'sd1; end
         4'd8: begin dx =  10'sd1; dy =  10'sd0; end
         4'd9: begin dx = -10'sd1; dy =  10'sd0; end
         4'd10: begin dx = 10'sd0; dy = 10'sd1; end
         default: begin dx = 10'sd0; dy = -10'sd1; end
      endcase
      nx = $signed({2'b00, px_ff}) + dx;
      ny = $signed({2'b00, py_ff}) + dy;
      nin = (nx >= 10'sd0) && (ny >= 10'sd0) && (nx < $signed({1'b0, ew})) &&
            (ny < $signed({1'b0, eh}));
      naddr = {ny[YW-1:0], nx[XW-1:0]};
   end

   logic [1:0]  rcmd;
   logic [7:0]  rx, ry;
   logic [1:0]  rcls;
   assign rcmd = req_tdata[1:0];
   assign rx   = req_tdata[9:2];
   assign ry   = req_tdata[17:10];
   assign rcls = req_tdata[19:18];

   logic req_acc;
   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign req_acc = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;

   logic sin_grid;
   assign sin_grid = ({1'b0, sx_ff} < ew) && ({1'b0, sy_ff} < eh);

   // memory ports, all addressed from registered state
   logic [AW-1:0] gaddr;
   logic          vwe, vwd;
   logic [AW-1:0] vaddr;
   always_comb begin
      gaddr = naddr;
      if (state_ff == S_POPRD || state_ff == S_CENTER) gaddr = {py_ff[YW-1:0], px_ff[XW-1:0]};
      vwe = 1'b0; vwd = 1'b1; vaddr = naddr;
      if (state_ff == S_CLEAR) begin
         vwe = 1'b1; vwd = 1'b0; vaddr = clr_ff;
      end else if (state_ff == S_PUSH) begin
         vwe = startq_ff || (grid_q == CLASS_FREE);
         if (startq_ff) vaddr = {sy_ff[YW-1:0], sx_ff[XW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      grid_q <= grid_mem[gaddr];
      vis_q  <= vis_mem[vaddr];
      q_q    <= q_mem[head_ff[15:0]];
      // writes outside the store are dropped
      if (state_ff == S_WRITE && int'(sx_ff) < MAX_GRID_WIDTH
          && int'(sy_ff) < MAX_GRID_HEIGHT)
         grid_mem[{sy_ff[YW-1:0], sx_ff[XW-1:0]}] <=
            (scls_ff == CLASS_OTHER) ? CLASS_BLOCKED : scls_ff;
      if (vwe) vis_mem[vaddr] <= vwd;
      if (state_ff == S_PUSH && vwe && !tail_ff[16])
         q_mem[tail_ff[15:0]] <= startq_ff ? {sy_ff, sx_ff} :
                                 {ny[7:0], nx[7:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; gw_ff <= 9'd256; gh_ff <= 9'd256;
         head_ff <= '0; tail_ff <= '0; rv_ff <= 1'b0; k_ff <= '0; startq_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index) gh_ff <= csr_data; else gw_ff <= csr_data;
         end
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(CELLS - 1)) begin
                  if (startq_ff && sin_grid) state_ff <= S_PUSH;
                  else begin startq_ff <= 1'b0; state_ff <= S_IDLE; end
               end
            end
            S_IDLE: if (req_acc) begin
               sx_ff <= rx; sy_ff <= ry; scls_ff <= rcls;
               case (cmd_type'(rcmd))
                  CMD_WRITE: state_ff <= S_WRITE;
                  CMD_START: begin
                     head_ff <= '0; tail_ff <= '0; clr_ff <= '0;
                     startq_ff <= 1'b1; state_ff <= S_CLEAR;
                  end
                  CMD_STEP: state_ff <= S_POP;
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_WRITE: state_ff <= S_IDLE;
            S_POP: begin
               if (head_ff >= tail_ff) begin
                  rd_ff <= 24'h040000; rv_ff <= 1'b1; state_ff <= S_IDLE;
               end else state_ff <= S_POPRD;
            end
            S_POPRD: begin
               // q_q now holds the head entry
               px_ff <= q_q[7:0]; py_ff <= q_q[15:8];
               head_ff <= head_ff + 17'd1;
               state_ff <= S_CENTER;
            end
            S_CENTER: state_ff <= S_NBR; // center address presented
            S_NBR: begin
               if (k_ff == 4'd0) cfree_ff <= (grid_q == CLASS_FREE);
               else if (k_ff <= 4'd8 && nin_d && grid_q == CLASS_UNKNOWN) unk_ff <= 1'b1;
               if (k_ff == 4'd0) unk_ff <= 1'b0;
               if (k_ff == 4'd8) begin
                  front_ff <= cfree_ff && (unk_ff ||
                              (nin_d && grid_q == CLASS_UNKNOWN));
                  state_ff <= S_VIS;
               end else k_ff <= k_ff + 4'd1;
            end
            S_VIS: begin
               if (k_ff == 4'd12) begin
                  k_ff <= '0; state_ff <= S_OUT;
               end else if (!nin) k_ff <= k_ff + 4'd1;
               else state_ff <= S_VISWAIT;
            end
            S_VISWAIT: begin
               if (vis_q) begin k_ff <= k_ff + 4'd1; state_ff <= S_VIS; end
               else state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (startq_ff) begin
                  startq_ff <= 1'b0;
                  if (!tail_ff[16]) tail_ff <= tail_ff + 17'd1;
                  state_ff <= S_IDLE;
               end else begin
                  if (grid_q == CLASS_FREE && !tail_ff[16]) tail_ff <= tail_ff + 17'd1;
                  k_ff <= k_ff + 4'd1; state_ff <= S_VIS;
               end
            end
            S_OUT: begin
               rd_ff <= {5'd0, (head_ff >= tail_ff), front_ff, 1'b1, py_ff, px_ff};
               rv_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // in-bounds flag of the cell whose grid read is returning now
   always_ff @(posedge clock) begin
      nin_d <= nin && (state_ff == S_NBR || state_ff == S_CENTER);
   end

   `ASSERT_IMPL(a_no_accept_busy, clock, reset, req_acc, !rv_ff && state_ff == S_IDLE)
   `ASSERT_IMPL(a_head_le_tail, clock, reset, state_ff == S_OUT, head_ff <= tail_ff)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && !rsp_tready, rv_ff && $stable(rd_ff))
endmodule

/* tb/frontier_flood_fill_checker.sv */
// Checker for frontier_flood_fill: watches the req, csr and rsp transfers, predicts each
// step result from its own copy of grid, visited map and queue, and compares.
// Depends on ffill_pkg.
module frontier_flood_fill_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data,
   output int          fail_count,
   output int          pending_results
);
   import ffill_pkg::*;

   // msb first: done[18] front[17] popped[16] y[15:8] x[7:0]
   typedef struct packed {
      logic       done;
      logic       front;
      logic       popped;
      logic [7:0] y;
      logic [7:0] x;
   } step_result_type;

   logic [1:0]   grid_cells [65536];
   bit           visited [65536];
   logic [15:0]  bfs_queue [$];
   step_result_type expected_steps [$];
   logic [8:0]   width_reg, height_reg;

   function automatic int clamp_size(logic [8:0] r);
      if (r == 9'd0) return 1;
      if (r > 9'd256) return 256;
      return int'(r);
   endfunction

   function automatic bit in_grid(int x, int y);
      return x >= 0 && y >= 0 && x < clamp_size(width_reg) && y < clamp_size(height_reg);
   endfunction

   function automatic bit touches_unknown(int x, int y);
      for (int dy = -1; dy <= 1; dy++)
         for (int dx = -1; dx <= 1; dx++)
            if ((dx != 0 || dy != 0) && in_grid(x + dx, y + dy))
               if (grid_cells[(y + dy) * 256 + x + dx] == CLASS_UNKNOWN) return 1'b1;
      return 1'b0;
   endfunction

   function automatic step_result_type pop_and_expand();
      step_result_type r;
      logic [15:0] e;
      int x, y, nx, ny;
      r = '0;
      if (bfs_queue.size() == 0) begin
         r.done = 1'b1;
         return r;
      end
      e = bfs_queue.pop_front();
      x = int'(e[7:0]);
      y = int'(e[15:8]);
      r.x = e[7:0];
      r.y = e[15:8];
      r.popped = 1'b1;
      r.front = grid_cells[y * 256 + x] == CLASS_FREE && touches_unknown(x, y);
      // neighbour order +x, -x, +y, -y
      for (int i = 0; i < 4; i++) begin
         nx = x + (i == 0 ? 1 : i == 1 ? -1 : 0);
         ny = y + (i == 2 ? 1 : i == 3 ? -1 : 0);
         if (in_grid(nx, ny) && !visited[ny * 256 + nx] &&
             grid_cells[ny * 256 + nx] == CLASS_FREE) begin
            bfs_queue.insert(bfs_queue.size(), {ny[7:0], nx[7:0]});
            visited[ny * 256 + nx] = 1'b1;
         end
      end
      r.done = bfs_queue.size() == 0;
      return r;
   endfunction

   always @(posedge clock) begin
      cmd_type      c;
      logic [7:0]   cx, cy;
      logic [1:0]   cls;
      step_result_type want, got;
      if (reset) begin
         width_reg = 9'd256;
         height_reg = 9'd256;
         foreach (visited[i]) visited[i] = 1'b0;
         bfs_queue.delete();
         expected_steps.delete();
         fail_count <= 0;
         pending_results <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index) height_reg = csr_data;
            else width_reg = csr_data;
         end
         if (req_tvalid && req_tready) begin
            c = cmd_type'(req_tdata[1:0]);
            cx = req_tdata[9:2];
            cy = req_tdata[17:10];
            cls = req_tdata[19:18];
            case (c)
               CMD_WRITE: grid_cells[{cy, cx}] = (cls == CLASS_OTHER) ? CLASS_BLOCKED : cls;
               CMD_START: begin
                  foreach (visited[i]) visited[i] = 1'b0;
                  bfs_queue.delete();
                  if (in_grid(int'(cx), int'(cy))) begin
                     bfs_queue.insert(bfs_queue.size(), {cy, cx});
                     visited[{cy, cx}] = 1'b1;
                  end
               end
               CMD_STEP: expected_steps.insert(expected_steps.size(), pop_and_expand());
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[18:0];
            if (expected_steps.size() == 0) begin
               $error("unexpected result transfer %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_steps.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (got.x !== want.x) $error("out_x expected %0d got %0d", want.x, got.x);
                  if (got.y !== want.y) $error("out_y expected %0d got %0d", want.y, got.y);
                  if (got.popped !== want.popped)
                     $error("popped_valid expected %0d got %0d", want.popped, got.popped);
                  if (got.front !== want.front)
                     $error("is_frontier expected %0d got %0d", want.front, got.front);
                  if (got.done !== want.done)
                     $error("search_done expected %0d got %0d", want.done, got.done);
               end
            end
         end
         pending_results <= expected_steps.size();
      end
   end
endmodule

/* tb/tb_frontier_flood_fill.sv */
// Testbench top for frontier_flood_fill: clock, reset, stimulus and verdict.
// Depends on ffill_pkg, frontier_flood_fill and frontier_flood_fill_checker.
module tb_frontier_flood_fill;
   import ffill_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // cmd[1:0] x[9:2] y[17:10] class[19:18]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // x[7:0] y[15:8] popped[16] front[17] done[18]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [8:0]  csr_data = '0;

   int fail_count, pending_results;
   int cycles = 0;
   bit calm = 1'b0;          // end of run: no idling on either side
   int hold_requests = 0;    // bumped to ask the receiver for one long hold-off
   bit written [65536];      // cells that a read may touch
   int cur_w = 256, cur_h = 256;

   always #5 clock = ~clock;

   frontier_flood_fill uut (.*);

   frontier_flood_fill_checker chk (.*);

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stall bursts, plus a long hold when asked
   always @(posedge clock) begin
      static int stall = 0;
      static int hold_seen = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         stall = 400;
         rsp_tready <= 1'b0;
      end else if (stall > 0) begin
         stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 11);
      end
   end

   // one req transfer; valid stays up unless a gap follows
   task automatic send_item(cmd_type c, logic [7:0] x, logic [7:0] y, logic [1:0] cls);
      if (c == CMD_WRITE) written[{y, x}] = 1'b1;
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, cls, y, x, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic idx, logic [8:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender waits until every expected step result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [1:0] pick_class();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return CLASS_FREE;
      if (r < 15) return CLASS_BLOCKED;
      if (r < 18) return CLASS_UNKNOWN;
      return CLASS_OTHER;
   endfunction

   // occasional noise: unused command or a rewrite somewhere in the store
   task automatic maybe_noise();
      if ($urandom_range(0, 19) == 0)
         send_item(CMD_NONE, 8'($urandom), 8'($urandom), 2'($urandom));
      else if ($urandom_range(0, 19) == 0)
         send_item(CMD_WRITE, 8'($urandom), 8'($urandom), pick_class());
   endtask

   // one search: size the grid, fill unwritten cells, start, step up to step_cap times (three for a start outside)
   task automatic run_search(logic [8:0] wreg, logic [8:0] hreg, bit start_outside,
                             bit long_hold, int step_cap);
      logic [7:0] sx, sy;
      int steps;
      write_csr(1'b0, wreg);
      write_csr(1'b1, hreg);
      cur_w = (wreg == 0) ? 1 : (wreg > 256) ? 256 : int'(wreg);
      cur_h = (hreg == 0) ? 1 : (hreg > 256) ? 256 : int'(hreg);
      for (int y = 0; y < cur_h; y++)
         for (int x = 0; x < cur_w; x++) begin
            if (!written[y * 256 + x]) send_item(CMD_WRITE, 8'(x), 8'(y), pick_class());
            maybe_noise();
         end
      if (start_outside) begin
         sx = (cur_w < 256) ? 8'($urandom_range(cur_w, 255)) : 8'($urandom);
         sy = (cur_w < 256) ? 8'($urandom) : 8'($urandom_range(cur_h, 255));
      end else begin
         sx = 8'($urandom_range(0, cur_w - 1));
         sy = 8'($urandom_range(0, cur_h - 1));
      end
      send_item(CMD_START, sx, sy, 2'($urandom));
      steps = cur_w * cur_h + 2;
      if (steps > step_cap) steps = step_cap;
      if (start_outside) steps = 3;
      for (int i = 0; i < steps; i++) begin
         send_item(CMD_STEP, 8'($urandom), 8'($urandom), 2'($urandom));
         // first result held off long, which stalls the steps behind it
         if (long_hold && i == 0) hold_requests++;
         // rewrite a cell inside the grid mid-search now and then
         if ($urandom_range(0, 29) == 0)
            send_item(CMD_WRITE, 8'($urandom_range(0, cur_w - 1)),
                      8'($urandom_range(0, cur_h - 1)), pick_class());
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // step on the empty queue right after reset
      send_item(CMD_STEP, 8'hff, 8'hff, 2'd3);
      drain();
      run_search(9'd0, 9'd0, 1'b0, 1'b0, 8);       // zero sizes act as 1x1
      run_search(9'd5, 9'd4, 1'b1, 1'b0, 3);       // start outside the grid
      run_search(9'd300, 9'd1, 1'b0, 1'b1, 60);    // width saturates to a full row, long hold
      run_search(9'($urandom_range(2, 8)), 9'($urandom_range(2, 8)), 1'b0, 1'b1, 200);
      calm = 1'b1;
      run_search(9'($urandom_range(2, 8)), 9'($urandom_range(2, 8)), 1'b0, 1'b0, 200);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl
rtl/ffill_pkg.sv
rtl/frontier_flood_fill.sv
tb/frontier_flood_fill_checker.sv
tb/tb_frontier_flood_fill.sv
